>>> rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/xs256_pkg.sv
// types and constants of the xoshiro256** generator
package xs256_pkg;

    localparam logic FUNC_SEED = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

    localparam int WORD_ROT     = 45;
    localparam int LANE_SHIFT   = 17;
    localparam int NARROW_SHIFT = 33;
    localparam int NARROW_W     = 31;

    typedef struct packed {
        logic        func;
        logic [63:0] seed_value;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MIX   = 6'b000010,
        ST_MULA  = 6'b000100,
        ST_MIDB  = 6'b001000,
        ST_MULB  = 6'b010000,
        ST_STORE = 6'b100000
    } state_t;

endpackage

>>> rtl/xs256_front.sv
// input acceptance and the item queue ahead of the generator core
`include "assert_macros.svh"

module xs256_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [63:0]         seed_value,
    output xs256_pkg::head_t    head,
    input  logic                pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    xs256_pkg::item_t     slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 do_pop;

    assign in_ready = (count_reg != FULL_CNT);
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg].func       <= func;
            slots_reg[wr_ptr_reg].seed_value <= seed_value;
        end
    end

    `ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT)
    `ASSERT_NOW(a_pop_nonempty, pop, count_reg != '0)
    `ASSERT_NEXT(a_push_grows, push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> rtl/xs256_back.sv
// generator state, splitmix64 seeding sequencer and draw datapath
`include "assert_macros.svh"

module xs256_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xs256_pkg::head_t     head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          random_value,
    output logic [30:0]          random_31,
    output logic                 unseeded_draw
);

    xs256_pkg::state_t state_reg;
    xs256_pkg::state_t state_next;
    logic [63:0]       words_reg [4];
    logic [63:0]       words_next [4];
    logic [63:0]       w1x5_reg;
    logic [63:0]       w1x5_next;
    logic              seeded_reg;
    logic              seeded_next;
    logic [63:0]       acc_reg;
    logic [63:0]       acc_next;
    logic [63:0]       opnd_reg;
    logic [63:0]       opnd_next;
    logic [63:0]       prod_reg;
    logic [63:0]       prod_next;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [63:0]       random_value_reg;
    logic [63:0]       random_value_next;
    logic              unseeded_reg;
    logic              unseeded_next;

    logic [63:0]       mul_const;
    logic [31:0]       mul_x;
    logic [31:0]       mul_y;
    logic [63:0]       mul_p;
    logic [63:0]       acc_sum;
    logic [63:0]       mix_out;
    logic [63:0]       rot5;
    logic [63:0]       scramble;
    logic [63:0]       t2;
    logic [63:0]       t3;
    logic [63:0]       n1;

    assign pop = head.valid && (state_reg == xs256_pkg::ST_IDLE)
                 && (!out_valid_reg || out_ready);

    assign mul_const = (state_reg == xs256_pkg::ST_MULB) ? xs256_pkg::MIX_MUL_B
                                                         : xs256_pkg::MIX_MUL_A;
    assign mul_x   = (step_reg == 2'd2) ? opnd_reg[63:32] : opnd_reg[31:0];
    assign mul_y   = (step_reg == 2'd1) ? mul_const[63:32] : mul_const[31:0];
    assign mul_p   = mul_x * mul_y;
    assign acc_sum = acc_reg + xs256_pkg::GOLDEN_GAMMA;
    assign mix_out = prod_reg ^ (prod_reg >> 31);

    // starstar scramble: rotl(w1 * 5, 7) * 9
    assign rot5     = {w1x5_reg[56:0], w1x5_reg[63:57]};
    assign scramble = (rot5 << 3) + rot5;

    assign t2 = words_reg[2] ^ words_reg[0];
    assign t3 = words_reg[3] ^ words_reg[1];
    assign n1 = words_reg[1] ^ t2;

    always_comb
    begin
        state_next        = state_reg;
        words_next        = words_reg;
        w1x5_next         = w1x5_reg;
        seeded_next       = seeded_reg;
        acc_next          = acc_reg;
        opnd_next         = opnd_reg;
        prod_next         = prod_reg;
        step_next         = step_reg;
        idx_next          = idx_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        random_value_next = random_value_reg;
        unseeded_next     = unseeded_reg;

        unique case (state_reg)
            xs256_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    if (head.item.func == xs256_pkg::FUNC_SEED)
                    begin
                        acc_next   = head.item.seed_value;
                        idx_next   = 2'd0;
                        state_next = xs256_pkg::ST_MIX;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (seeded_reg)
                        begin
                            random_value_next = scramble;
                            unseeded_next     = 1'b0;
                            words_next[0]     = words_reg[0] ^ t3;
                            words_next[1]     = n1;
                            words_next[2]     = t2 ^ (words_reg[1] << xs256_pkg::LANE_SHIFT);
                            words_next[3]     = {t3[63-xs256_pkg::WORD_ROT:0],
                                                 t3[63:64-xs256_pkg::WORD_ROT]};
                            w1x5_next         = (n1 << 2) + n1;
                        end
                        else
                        begin
                            random_value_next = '0;
                            unseeded_next     = 1'b1;
                        end
                    end
                end
            end
            xs256_pkg::ST_MIX:
            begin
                acc_next   = acc_sum;
                opnd_next  = acc_sum ^ (acc_sum >> 30);
                step_next  = 2'd0;
                state_next = xs256_pkg::ST_MULA;
            end
            xs256_pkg::ST_MULA,
            xs256_pkg::ST_MULB:
            begin
                if (step_reg == 2'd0)
                begin
                    prod_next = mul_p;
                end
                else
                begin
                    prod_next[63:32] = prod_reg[63:32] + mul_p[31:0];
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    step_next  = 2'd0;
                    state_next = (state_reg == xs256_pkg::ST_MULA) ? xs256_pkg::ST_MIDB
                                                                   : xs256_pkg::ST_STORE;
                end
            end
            xs256_pkg::ST_MIDB:
            begin
                opnd_next  = prod_reg ^ (prod_reg >> 27);
                state_next = xs256_pkg::ST_MULB;
            end
            xs256_pkg::ST_STORE:
            begin
                words_next[idx_reg] = mix_out;
                if (idx_reg == 2'd1)
                begin
                    w1x5_next = (mix_out << 2) + mix_out;
                end
                if (idx_reg == 2'd3)
                begin
                    seeded_next       = 1'b1;
                    out_valid_next    = 1'b1;
                    random_value_next = '0;
                    unseeded_next     = 1'b0;
                    state_next        = xs256_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = xs256_pkg::ST_MIX;
                end
            end
            default:
            begin
                state_next = xs256_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= xs256_pkg::ST_IDLE;
            words_reg        <= '{default: '0};
            w1x5_reg         <= '0;
            seeded_reg       <= 1'b0;
            step_reg         <= '0;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
            random_value_reg <= '0;
            unseeded_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            words_reg        <= words_next;
            w1x5_reg         <= w1x5_next;
            seeded_reg       <= seeded_next;
            step_reg         <= step_next;
            idx_reg          <= idx_next;
            out_valid_reg    <= out_valid_next;
            random_value_reg <= random_value_next;
            unseeded_reg     <= unseeded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        prod_reg <= prod_next;
    end

    assign out_valid     = out_valid_reg;
    assign random_value  = random_value_reg;
    assign random_31     = random_value_reg[63 -: xs256_pkg::NARROW_W];
    assign unseeded_draw = unseeded_reg;

    `ASSERT_NOW(a_pop_idle, pop, state_reg == xs256_pkg::ST_IDLE)
    `ASSERT_NOW(a_w1x5_track, 1'b1, w1x5_reg == (words_reg[1] << 2) + words_reg[1])
    `ASSERT_NOW(a_flag_zero, out_valid_reg && unseeded_reg, random_value_reg == '0)
    `ASSERT_NOW(a_flag_unseeded, out_valid_reg && unseeded_reg, !seeded_reg)

endmodule

>>> rtl/xoshiro256ss_generator.sv
// top level of the xoshiro256** generator with splitmix64 seeding
// draw: queued, then popped into the output register; one draw per cycle sustained while
//   out_ready is high and no seed runs; seed: four splitmix64 rounds of MIX, MULA, MIDB,
//   MULB and STORE, the shared 32x32 multiplier taking three partial products per multiply
// the input queue accepts while the core is busy, up to QUEUE_DEPTH items
// reset clears the state words, the seeded flag, the queue and the output register
module xoshiro256ss_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [63:0] seed_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] random_value,
    output logic [30:0] random_31,
    output logic        unseeded_draw
);

    xs256_pkg::head_t head;
    logic             pop;

    xs256_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .seed_value (seed_value),
        .head       (head),
        .pop        (pop)
    );

    xs256_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .random_value  (random_value),
        .random_31     (random_31),
        .unseeded_draw (unseeded_draw)
    );

endmodule
